// ----- src/eos_pkg.sv -----
// ----------------------------------------------------------------------------
// eos_pkg
// Shared widths, constants, register indexes and controller/datapath types
// for the encoder odometry sampler.
// ----------------------------------------------------------------------------
package eos_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;

  localparam int CNT_IN_W  = 16;
  localparam int TIME_W    = 16;
  localparam int COEF_W    = 32;
  localparam int POS_W     = 32;
  localparam int TOTAL_W   = 64;
  localparam int STEP_W    = 48;
  localparam int SPEED_W   = 64;
  localparam int MUL_W     = 32;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR     = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] TIME_ZERO_SUBST = 16'hffff;
  localparam logic [MUL_W-1:0]  US_PER_SECOND   = 32'd1000000;

  // Speed dividend: step magnitude (below 2^63) times 10^6 (below 2^20)
  localparam int US_W      = 20;
  localparam int NUM_W     = SPEED_W + US_W;
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    MUL_POS,
    MUL_STEP,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear_item;
    mul_sel_t mul_sel;
    logic     cap_total;
    logic     cap_step;
    logic     cap_lo;
    logic     sum;
    logic     div_step;
    logic     finish;
    logic     publish;
  } eos_cmd_t;

  typedef struct packed {
    logic div_last;
  } eos_status_t;

endpackage

// ----- src/eos_in_if.sv -----
// ----------------------------------------------------------------------------
// eos_in_if
// Sample channel: valid/ready handshake carrying kind, counter and timestamp.
// ----------------------------------------------------------------------------
interface eos_in_if
  import eos_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [CNT_IN_W-1:0] counter_value;
  logic [TIME_W-1:0]   time_us;

  modport source (output valid, kind, counter_value, time_us, input ready);
  modport sink   (input valid, kind, counter_value, time_us, output ready);
endinterface

// ----- src/eos_out_if.sv -----
// ----------------------------------------------------------------------------
// eos_out_if
// Result channel: valid/ready handshake carrying distances, speed and time.
// ----------------------------------------------------------------------------
interface eos_out_if
  import eos_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] total_distance;
  logic signed [STEP_W-1:0]  step_distance;
  logic signed [SPEED_W-1:0] speed;
  logic        [TIME_W-1:0]  elapsed_us;

  modport source (output valid, total_distance, step_distance, speed, elapsed_us,
                  input ready);
  modport sink   (input valid, total_distance, step_distance, speed, elapsed_us,
                  output ready);
endinterface

// ----- src/eos_cfg_if.sv -----
// ----------------------------------------------------------------------------
// eos_cfg_if
// Configuration write channel: valid/ready handshake, register index, data.
// ----------------------------------------------------------------------------
interface eos_cfg_if
  import eos_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ----- src/eos_ctrl.sv -----
// ----------------------------------------------------------------------------
// eos_ctrl
// Sequencer: steps the shared multiplier, the divider and the output slot.
// ----------------------------------------------------------------------------
module eos_ctrl
  import eos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  eos_status_t status,
  output eos_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_S,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_FIN,
    ST_PUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   accept;
  logic   slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = MUL_POS;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load       = accept;
        cmd.clear_item = accept && in_kind;
        if (accept) begin
          state_nxt = in_kind ? ST_PUT : ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_sel = MUL_POS;
        state_nxt   = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_sel   = MUL_STEP;
        cmd.cap_total = 1'b1;
        state_nxt     = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_sel  = MUL_LO;
        cmd.cap_step = 1'b1;
        state_nxt    = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_sel = MUL_HI;
        cmd.cap_lo  = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_PUT;
      end
      ST_PUT: begin
        cmd.publish = slot_free;
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- src/eos_dp.sv -----
// ----------------------------------------------------------------------------
// eos_dp
// Datapath: sample state, shared 32x32 multiplier, radix-4 speed divider,
// saturation and the output register.
// ----------------------------------------------------------------------------
module eos_dp
  import eos_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  eos_cmd_t              cmd,
  output eos_status_t           status,
  input  logic [CNT_IN_W-1:0]   in_counter_value,
  input  logic [TIME_W-1:0]     in_time_us,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [TOTAL_W-1:0]    out_total_distance,
  output logic [STEP_W-1:0]     out_step_distance,
  output logic [SPEED_W-1:0]    out_speed,
  output logic [TIME_W-1:0]     out_elapsed_us
);

  localparam int CW = COUNTER_WIDTH;

  // architectural state
  logic [COEF_W-1:0] dpc_r;
  logic              inv_r;
  logic [TIME_W-1:0] prev_time_r;
  logic [CW-1:0]     prev_cnt_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // per-item working registers
  logic [TIME_W-1:0]    dt_r;
  logic [CW-1:0]        dmag_r;
  logic                 dneg_r;
  logic [2*MUL_W-1:0]   mul_r;
  logic [2*MUL_W-1:0]   smag_r;
  logic [2*MUL_W-1:0]   lo_r;
  logic [TOTAL_W-1:0]   tot_r;
  logic [STEP_W-1:0]    step_r;
  logic [SPEED_W-1:0]   spd_r;
  logic [NUM_W-1:0]     num_r;
  logic [TIME_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // sample decode
  logic [31:0]    cnt_ext;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  d;
  logic           dneg;
  logic [CW-1:0]  dmag;

  assign cnt_ext = {16'b0, in_counter_value};
  assign cnt     = cnt_ext[CW-1:0];
  assign d       = cnt - prev_cnt_r;
  assign dneg    = d[CW-1];
  assign dmag    = dneg ? -d : d;
  assign pos_nxt = pos_r + POS_W'($signed(d));

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [POS_W-1:0]   pmag;
  logic               pneg;

  assign pneg = pos_r[POS_W-1];
  assign pmag = pneg ? -pos_r : pos_r;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_POS:  begin mul_a = pmag;                     mul_b = dpc_r;         end
      MUL_STEP: begin mul_a = MUL_W'(dmag_r);           mul_b = dpc_r;         end
      MUL_LO:   begin mul_a = mul_r[MUL_W-1:0];         mul_b = US_PER_SECOND; end
      MUL_HI:   begin mul_a = smag_r[2*MUL_W-1:MUL_W];  mul_b = US_PER_SECOND; end
      default:  begin mul_a = pmag;                     mul_b = dpc_r;         end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // result signs
  logic               tot_neg, spd_neg;
  logic [TOTAL_W-1:0] tot_val;
  logic [TOTAL_W-1:0] step_val;

  assign tot_neg  = pneg ^ inv_r;
  assign spd_neg  = dneg_r ^ inv_r;
  assign tot_val  = tot_neg ? -mul_r : mul_r;
  assign step_val = spd_neg ? -mul_r : mul_r;

  // divider: two quotient bits a cycle
  logic [TIME_W-1:0] dv;
  logic [TIME_W:0]   dv_x, t1, t2;
  logic              ge1, ge2;
  logic [TIME_W-1:0] r1, r2;

  assign dv   = (dt_r == '0) ? TIME_ZERO_SUBST : dt_r;
  assign dv_x = {1'b0, dv};
  assign t1   = {rem_r, num_r[NUM_W-1]};
  assign ge1  = (t1 >= dv_x);
  assign r1   = ge1 ? TIME_W'(t1 - dv_x) : t1[TIME_W-1:0];
  assign t2   = {r1, num_r[NUM_W-2]};
  assign ge2  = (t2 >= dv_x);
  assign r2   = ge2 ? TIME_W'(t2 - dv_x) : t2[TIME_W-1:0];

  assign status.div_last = (div_cnt_r == DIV_CNT_W'(1));

  // saturation of the quotient
  logic [SPEED_W-1:0] lim;
  logic [SPEED_W-1:0] qm;
  logic               over;

  assign lim  = spd_neg ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
  assign over = (|num_r[NUM_W-1:SPEED_W]) || (num_r[SPEED_W-1:0] > lim);
  assign qm   = over ? lim : num_r[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r       <= '0;
      inv_r       <= 1'b0;
      prev_time_r <= '0;
      prev_cnt_r  <= '0;
      pos_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIST_PER_COUNT) begin
          dpc_r <= cfg_data;
        end else if (cfg_index == REG_INVERT_DIR) begin
          inv_r <= cfg_data[0];
        end
      end
      if (cmd.load) begin
        if (cmd.clear_item) begin
          prev_cnt_r <= '0;
          pos_r      <= '0;
        end else begin
          prev_time_r <= in_time_us;
          prev_cnt_r  <= cnt;
          pos_r       <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    if (cmd.load) begin
      dt_r   <= cmd.clear_item ? '0 : in_time_us - prev_time_r;
      dmag_r <= dmag;
      dneg_r <= dneg;
      if (cmd.clear_item) begin
        tot_r  <= '0;
        step_r <= '0;
        spd_r  <= '0;
      end
    end
    if (cmd.cap_total) begin
      tot_r <= tot_val;
    end
    if (cmd.cap_step) begin
      smag_r <= mul_r;
      step_r <= step_val[STEP_W-1:0];
    end
    if (cmd.cap_lo) begin
      lo_r <= mul_r;
    end
    if (cmd.sum) begin
      num_r     <= NUM_W'(lo_r) + (NUM_W'(mul_r) << MUL_W);
      rem_r     <= '0;
      div_cnt_r <= DIV_CNT_W'(DIV_STEPS);
    end
    if (cmd.div_step) begin
      num_r     <= {num_r[NUM_W-3:0], ge1, ge2};
      rem_r     <= r2;
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
    if (cmd.finish) begin
      spd_r <= spd_neg ? -qm : qm;
    end
    if (cmd.publish) begin
      out_total_distance <= tot_r;
      out_step_distance  <= step_r;
      out_speed          <= spd_r;
      out_elapsed_us     <= dt_r;
    end
  end

endmodule

// ----- src/encoder_odometry_sampler_core.sv -----
// ----------------------------------------------------------------------------
// encoder_odometry_sampler_core
// Quadrature counter odometry: position, step distance and speed per sample.
// ----------------------------------------------------------------------------
// Each sample transaction passes through the sequencer before the next is
// accepted: four passes through one shared 32x32 multiplier (position,
// step, and the two halves of step times 10^6), one step to assemble the
// 84-bit dividend, a radix-4 restoring divider for speed, one step of
// saturation and one to load the output register. A clear transaction
// goes straight to loading the output register. The finished result sits
// in its own output register, so the next sample is accepted while an
// earlier result still waits to be taken; the sequencer only holds off
// when a second result is ready and the output register is still full.
// Configuration writes are always accepted and take effect at once; write
// them only while no sample is in flight.
// ----------------------------------------------------------------------------
module encoder_odometry_sampler_core
  import eos_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst_n,
  eos_in_if.sink  in_ch,
  eos_out_if.source out_ch,
  eos_cfg_if.sink cfg_ch
);

  eos_cmd_t    cmd;
  eos_status_t status;

  logic [TOTAL_W-1:0] total_q;
  logic [STEP_W-1:0]  step_q;
  logic [SPEED_W-1:0] speed_q;

  // register file never stalls a write
  assign cfg_ch.ready = 1'b1;

  eos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  eos_dp #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_counter_value   (in_ch.counter_value),
    .in_time_us         (in_ch.time_us),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.reg_index),
    .cfg_data           (cfg_ch.data),
    .out_total_distance (total_q),
    .out_step_distance  (step_q),
    .out_speed          (speed_q),
    .out_elapsed_us     (out_ch.elapsed_us)
  );

  // present the two's-complement results as signed fields
  assign out_ch.total_distance = $signed(total_q);
  assign out_ch.step_distance  = $signed(step_q);
  assign out_ch.speed          = $signed(speed_q);

endmodule
